// ===== rtl/pnfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnfg_pkg
// Types, codes and constants of the per-node frame gap statistics unit.
// ----------------------------------------------------------------------------
package pnfg_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int MASK_BITS      = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int TYPE_W         = 13;

    localparam logic [31:0] PERIOD_US   = 32'd2000;
    localparam logic [31:0] HALF_PERIOD = 32'd1000;
    localparam logic [31:0] MISS_LIMIT  = 32'd3000;
    // ceil(2^36 / 125): (gap + 1000) / 2000 == ((gap + 1000) >> 4) * RECIP >> 36
    localparam logic [29:0] PERIOD_RECIP = 30'd549755814;
    localparam int          RECIP_SHIFT  = 36;

    typedef enum logic [1:0] {
        FUNC_FRAME = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_DROPPED = 3'd0,
        KIND_POSVEL  = 3'd1,
        KIND_TEMPS   = 3'd2,
        KIND_OTHER   = 3'd3,
        KIND_STAT    = 3'd4,
        KIND_BAD     = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        SEL_LAST     = 4'd0,
        SEL_MIN      = 4'd1,
        SEL_MAX      = 4'd2,
        SEL_SUM      = 4'd3,
        SEL_GAPS     = 4'd4,
        SEL_MISSED   = 4'd5,
        SEL_FRAMES   = 4'd6,
        SEL_SEEN     = 4'd7,
        SEL_COUNTER  = 4'd8,
        SEL_DUPS     = 4'd9,
        SEL_JUMPS    = 4'd10,
        SEL_JSKIP    = 4'd11,
        SEL_GLOBAL   = 4'd12
    } stat_sel_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COUNTER_MODE = 2'd0,
        REG_NODE_MASK    = 2'd1,
        REG_POSVEL_TYPE  = 2'd2,
        REG_TEMPS_TYPE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [28:0] frame_id;
        logic [31:0] payload_low;
        logic [31:0] payload_high;
        logic [31:0] arrival_time_us;
        logic [7:0]  query_node;
        logic [3:0]  stat_select;
    } in_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  node;
        logic [31:0] word_first;
        logic [31:0] word_second;
        logic        update_position;
        logic [31:0] update_time_us;
        logic [31:0] stat_value;
    } out_t;

    typedef struct packed {
        logic [31:0] last_rx_time;
        logic [31:0] min_gap;
        logic [31:0] max_gap;
        logic [31:0] gap_sum;
        logic [31:0] gap_total;
        logic [31:0] missed_estimate;
        logic [31:0] frame_total;
        logic        counter_valid;
        logic [31:0] previous_counter;
        logic [31:0] duplicate_total;
        logic [31:0] jump_events;
        logic [31:0] jump_skipped;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        last_rx_time:     32'd0,
        min_gap:          32'hFFFF_FFFF,
        max_gap:          32'd0,
        gap_sum:          32'd0,
        gap_total:        32'd0,
        missed_estimate:  32'd0,
        frame_total:      32'd0,
        counter_valid:    1'b0,
        previous_counter: 32'd0,
        duplicate_total:  32'd0,
        jump_events:      32'd0,
        jump_skipped:     32'd0
    };

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } mem_ctl_t;

endpackage

// ===== rtl/pnfg_stat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnfg_stat_mem
// Per-node statistics store: one wide entry per node, registered read, and
// a valid bit per entry so that a clear needs no sweep of the store.
// ----------------------------------------------------------------------------
module pnfg_stat_mem #(
    parameter int NODE_COUNT = pnfg_pkg::NODE_COUNT_DEF,
    parameter int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pnfg_pkg::mem_ctl_t  ctl,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  pnfg_pkg::entry_t    wr_data,
    output pnfg_pkg::entry_t    rd_entry
);
    import pnfg_pkg::*;

    entry_t                 mem [NODE_COUNT];
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [NODE_COUNT-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // entry never written since the last clear reads as its reset value
    assign rd_entry = rd_valid_reg ? rd_data_reg : ENTRY_RESET;

endmodule

// ===== rtl/pnfg_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnfg_round
// Single-precision float to int32: round half away from zero, saturating,
// NaN and subnormals give zero.
// ----------------------------------------------------------------------------
module pnfg_round (
    input  logic [31:0] fbits,
    output logic [31:0] value
);
    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [23:0] mant;
    logic [7:0]  lsh;
    logic [7:0]  rsh;
    logic [24:0] rsum;
    logic [31:0] mag;

    always_comb
    begin
        sgn  = fbits[31];
        expo = fbits[30:23];
        frac = fbits[22:0];
        mant = {1'b1, frac};
        lsh  = 8'(expo - 8'd150);
        rsh  = 8'(8'd150 - expo);
        rsum = 25'(mant) + (25'd1 << (rsh - 8'd1));
        mag  = 32'd0;
        value = 32'd0;
        priority if (expo == 8'hFF && frac != 23'd0)
        begin
            value = 32'd0;
        end
        else if (expo < 8'd126)
        begin
            value = 32'd0;
        end
        else if (expo >= 8'd158)
        begin
            value = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            if (expo >= 8'd150)
            begin
                mag = 32'(mant) << lsh[2:0];
            end
            else
            begin
                mag = 32'(rsum >> rsh);
            end
            value = sgn ? (32'd0 - mag) : mag;
        end
    end

endmodule

// ===== rtl/per_node_frame_gap_statistics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_node_frame_gap_statistics_unit
// Per-node CAN frame gap statistics with read and clear commands.
//
//   channel   signals                               beat
//   in        in_valid / in_ready / in_data         one frame or command
//   out       out_valid / out_ready / out_data      one result
//   cfg       cfg_we / cfg_addr / cfg_wdata         one register write
//
// Each item passes in turn through accept with memory read, gap and
// counter decode, period multiply and write-back; a new item is taken
// only after the write-back of the last one (read-modify-write of the store).
// Reset sets control and config to defaults and clears the valid bits; the store needs no sweep.
// A clear command resets all entries at once through the valid bits.
// Write-back waits while a previous result is still held on out.
// ----------------------------------------------------------------------------
module per_node_frame_gap_statistics_unit #(
    parameter int NODE_COUNT = pnfg_pkg::NODE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pnfg_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pnfg_pkg::out_t                    out_data,
    input  logic                              cfg_we,
    input  logic [pnfg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pnfg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import pnfg_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    state_t           state_reg, state_next;
    in_t              in_reg;
    logic             counter_mode_reg;
    logic [15:0]      node_mask_reg;
    logic [12:0]      posvel_type_reg;
    logic [12:0]      temps_type_reg;
    logic [31:0]      any_last_reg;
    logic [31:0]      gap_reg;
    logic [28:0]      x_reg;
    logic [22:0]      periods_reg;
    logic [31:0]      ctr_reg;
    out_t             out_reg, out_next;
    logic             out_valid_reg;

    mem_ctl_t         mem_ctl;
    entry_t           entry;
    entry_t           entry_new;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      ctr_val;
    logic [58:0]      prod;
    logic [31:0]      gap_now;
    logic             advance;
    logic             accept;

    logic [7:0]       sender;
    logic [12:0]      mtype;
    logic             mapped;
    logic             is_posvel;
    logic             is_temps;
    logic             query_ok;
    logic [31:0]      delta;
    logic [31:0]      stat;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign advance  = !out_valid_reg || out_ready;

    assign rd_addr  = (func_t'(in_data.func) == FUNC_READ) ? in_data.query_node[IDX_W-1:0]
                                                           : in_data.frame_id[IDX_W-1:0];
    assign wr_addr  = in_reg.frame_id[IDX_W-1:0];

    assign sender    = in_reg.frame_id[7:0];
    assign mtype     = in_reg.frame_id[28:16];
    assign mapped    = (9'(sender) < 9'(NODE_COUNT)) && (sender < 8'(MASK_BITS))
                       && node_mask_reg[sender[3:0]];
    assign is_posvel = (mtype == posvel_type_reg);
    assign is_temps  = (mtype == temps_type_reg);
    assign query_ok  = 9'(in_reg.query_node) < 9'(NODE_COUNT);

    pnfg_stat_mem #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (entry_new),
        .rd_entry (entry)
    );

    pnfg_round u_round (
        .fbits (in_reg.payload_low),
        .value (ctr_val)
    );

    // gap wraps at 32 bits
    assign gap_now  = in_reg.arrival_time_us - entry.last_rx_time;
    assign prod     = x_reg * PERIOD_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            counter_mode_reg <= 1'b0;
            node_mask_reg    <= 16'd0;
            posvel_type_reg  <= 13'd1;
            temps_type_reg   <= 13'd2;
            any_last_reg     <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WRITE && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_COUNTER_MODE: counter_mode_reg <= cfg_wdata[0];
                    REG_NODE_MASK:    node_mask_reg    <= cfg_wdata;
                    REG_POSVEL_TYPE:  posvel_type_reg  <= cfg_wdata[12:0];
                    REG_TEMPS_TYPE:   temps_type_reg   <= cfg_wdata[12:0];
                endcase
            end
            if (mem_ctl.clr_all)
            begin
                any_last_reg <= 32'd0;
            end
            else if (mem_ctl.wr_en)
            begin
                any_last_reg <= in_reg.arrival_time_us;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (state_reg == ST_READ)
        begin
            gap_reg <= gap_now;
            x_reg   <= 29'((33'(gap_now) + 33'(HALF_PERIOD)) >> 4);
            ctr_reg <= ctr_val;
        end
        if (state_reg == ST_MUL)
        begin
            periods_reg <= prod[RECIP_SHIFT +: 23];
        end
        if (state_reg == ST_WRITE && advance)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_WRITE;
            ST_WRITE: if (advance) state_next = ST_IDLE;
        endcase
    end

    // new entry for a position/velocity frame
    always_comb
    begin
        entry_new = entry;
        delta     = ctr_reg - entry.previous_counter;
        if (entry.last_rx_time != 32'd0)
        begin
            if (gap_reg < entry.min_gap) entry_new.min_gap = gap_reg;
            if (gap_reg > entry.max_gap) entry_new.max_gap = gap_reg;
            entry_new.gap_sum   = entry.gap_sum + gap_reg;
            entry_new.gap_total = entry.gap_total + 32'd1;
            if (gap_reg > MISS_LIMIT)
            begin
                entry_new.missed_estimate = entry.missed_estimate
                                            + 32'(periods_reg) - 32'd1;
            end
        end
        entry_new.last_rx_time = in_reg.arrival_time_us;
        entry_new.frame_total  = entry.frame_total + 32'd1;
        if (counter_mode_reg)
        begin
            if (entry.counter_valid)
            begin
                if (ctr_reg == entry.previous_counter)
                begin
                    entry_new.duplicate_total = entry.duplicate_total + 32'd1;
                end
                else if (delta > 32'd1)
                begin
                    entry_new.jump_events  = entry.jump_events + 32'd1;
                    entry_new.jump_skipped = entry.jump_skipped + delta - 32'd1;
                end
            end
            entry_new.previous_counter = ctr_reg;
            entry_new.counter_valid    = 1'b1;
        end
    end

    always_comb
    begin
        unique case (stat_sel_t'(in_reg.stat_select))
            SEL_LAST:    stat = entry.last_rx_time;
            SEL_MIN:     stat = entry.min_gap;
            SEL_MAX:     stat = entry.max_gap;
            SEL_SUM:     stat = entry.gap_sum;
            SEL_GAPS:    stat = entry.gap_total;
            SEL_MISSED:  stat = entry.missed_estimate;
            SEL_FRAMES:  stat = entry.frame_total;
            SEL_SEEN:    stat = 32'(entry.counter_valid);
            SEL_COUNTER: stat = entry.previous_counter;
            SEL_DUPS:    stat = entry.duplicate_total;
            SEL_JUMPS:   stat = entry.jump_events;
            SEL_JSKIP:   stat = entry.jump_skipped;
            SEL_GLOBAL:  stat = any_last_reg;
            default:     stat = 32'd0;
        endcase
    end

    always_comb
    begin
        out_next = '0;
        mem_ctl  = '0;
        mem_ctl.rd_en = accept;
        unique case (func_t'(in_reg.func))
            FUNC_FRAME:
            begin
                out_next.node = sender;
                priority if (!mapped)
                begin
                    out_next.result_kind = KIND_DROPPED;
                end
                else if (is_posvel)
                begin
                    out_next.result_kind     = KIND_POSVEL;
                    out_next.word_first      = in_reg.payload_low;
                    out_next.word_second     = in_reg.payload_high;
                    out_next.update_position = !counter_mode_reg;
                    out_next.update_time_us  = in_reg.arrival_time_us;
                    mem_ctl.wr_en = (state_reg == ST_WRITE) && advance;
                end
                else if (is_temps)
                begin
                    out_next.result_kind = KIND_TEMPS;
                    out_next.word_first  = in_reg.payload_low;
                    out_next.word_second = in_reg.payload_high;
                end
                else
                begin
                    out_next.result_kind = KIND_OTHER;
                end
            end
            FUNC_READ:
            begin
                out_next.node = in_reg.query_node;
                if (query_ok)
                begin
                    out_next.result_kind = KIND_STAT;
                    out_next.stat_value  = stat;
                end
                else
                begin
                    out_next.result_kind = KIND_BAD;
                end
            end
            FUNC_CLEAR:
            begin
                out_next.result_kind = KIND_BAD;
                mem_ctl.clr_all = (state_reg == ST_WRITE) && advance;
            end
            FUNC_NONE:
            begin
                out_next.result_kind = KIND_DROPPED;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
